### design/cmst_pkg.sv
package cmst_pkg;

  // Channel count: 1 to 4 compare channels
  localparam int NUM_CHANNELS = 4;

  // Field widths
  localparam int OP_W    = 2;
  localparam int SEL_W   = 3;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 64;
  localparam int FLAG_W  = 4;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Register map
  typedef enum logic [SEL_W-1:0] {
    SEL_STATUS = 3'd0,
    SEL_CNT_LO = 3'd1,
    SEL_CNT_HI = 3'd2,
    SEL_CMP0   = 3'd3,
    SEL_CMP1   = 3'd4,
    SEL_CMP2   = 3'd5,
    SEL_CMP3   = 3'd6,
    SEL_NONE   = 3'd7
  } sel_t;

  // One registered input beat
  typedef struct packed {
    op_t               op;
    sel_t              reg_select;
    logic [DATA_W-1:0] write_data;
  } item_t;

  // Handshake between input stage and core
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

### design/cmst_if.sv
interface cmst_in_if;
  import cmst_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output op, output reg_select, output write_data,
                  input ready);
  modport sink   (input valid, input op, input reg_select, input write_data,
                  output ready);
endinterface

interface cmst_out_if;
  import cmst_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [FLAG_W-1:0] match_flags;
  logic              irq_line;

  modport source (output valid, output read_data, output match_flags, output irq_line,
                  input ready);
  modport sink   (input valid, input read_data, input match_flags, input irq_line,
                  output ready);
endinterface

### design/cmst_in_stage.sv
module cmst_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  cmst_in_if.sink         in_bus,
  input  logic            advance,
  output cmst_pkg::item_t item,
  output logic            item_valid
);
  import cmst_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Accept a new beat when the slot is empty or drains this cycle
  assign in_bus.ready = !valid_r || advance;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.op         <= op_t'(in_bus.op);
      item_r.reg_select <= sel_t'(in_bus.reg_select);
      item_r.write_data <= in_bus.write_data;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

### design/cmst_core.sv
module cmst_core (
  input  logic               clk,
  input  logic               rst_n,
  input  cmst_pkg::item_t    item,
  input  logic               item_valid,
  output cmst_pkg::stage_ctl_t ctl,
  cmst_out_if.source         out_bus
);
  import cmst_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [DATA_W-1:0]       cmp_r   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] flags_r;
  logic [NUM_CHANNELS-1:0] flags_nxt;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [DATA_W-1:0]       read_data_r;
  logic [DATA_W-1:0]       read_data_nxt;
  logic [FLAG_W-1:0]       match_flags_r;
  logic                    irq_line_r;

  logic                    advance;
  logic [CNT_W-1:0]        count_inc;
  logic [NUM_CHANNELS-1:0] hits;
  logic [SEL_W-1:0]        ch_full;
  logic [CH_IDX_W-1:0]     ch_idx;
  logic                    is_cmp;
  logic                    cmp_we;

  // Move the held beat into the result register when that slot is free
  assign advance     = item_valid && (!out_valid_r || out_bus.ready);
  assign ctl.valid   = item_valid;
  assign ctl.advance = advance;

  // Compare-channel decode; absent channels and the unused select fall out here
  assign ch_full = item.reg_select - SEL_CMP0;
  assign ch_idx  = ch_full[CH_IDX_W-1:0];
  assign is_cmp  = (item.reg_select >= SEL_CMP0) && (ch_full < SEL_W'(NUM_CHANNELS));

  // Counter increment and per-channel match on the new low word
  assign count_inc = count_r + CNT_W'(1);
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      hits[c] = (cmp_r[c] == count_inc[DATA_W-1:0]);
    end
  end

  // Next state and read data for this beat
  always_comb begin
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    read_data_nxt = '0;
    cmp_we        = 1'b0;
    case (item.op)
      OP_TICK: begin
        count_nxt = count_inc;
        flags_nxt = flags_r | hits;
      end
      OP_READ: begin
        case (item.reg_select)
          SEL_STATUS: read_data_nxt = DATA_W'(flags_r);
          SEL_CNT_LO: read_data_nxt = count_r[DATA_W-1:0];
          SEL_CNT_HI: read_data_nxt = count_r[CNT_W-1:DATA_W];
          default:    read_data_nxt = is_cmp ? cmp_r[ch_idx] : '0;
        endcase
      end
      OP_WRITE: begin
        if (item.reg_select == SEL_STATUS) begin
          flags_nxt = flags_r & ~item.write_data[NUM_CHANNELS-1:0];
        end
        cmp_we = is_cmp;
      end
      default: ;
    endcase
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flags_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cmp_r[c] <= '0;
      end
    end else if (advance) begin
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      if (cmp_we) begin
        cmp_r[ch_idx] <= item.write_data;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data_r   <= read_data_nxt;
      match_flags_r <= FLAG_W'(flags_nxt);
      irq_line_r    <= |flags_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.read_data   = read_data_r;
  assign out_bus.match_flags = match_flags_r;
  assign out_bus.irq_line    = irq_line_r;

endmodule

### design/compare_match_system_timer.sv
// Compare-match system timer: a 64-bit free-running counter that steps on each
// tick beat, up to four 32-bit compare channels whose match flags set when the
// new low counter word equals the channel's compare value, and a bus view of
// status, counter halves and compare registers (write 1 to a status bit to
// clear it; counter writes are dropped; the two counter halves are read
// independently, not as a latched pair). Each input beat yields exactly one
// result beat carrying read data (zero except on reads), the flags after the
// beat, and the interrupt line. Throughput is one beat per clock while the
// output is ready; each beat passes through the input register and then the
// result register. The input ready follows the output ready combinationally
// when both stages are full, and the only long path is the 64-bit counter
// increment feeding the 32-bit compare of each channel.
module compare_match_system_timer (
  input  logic       clk,
  input  logic       rst_n,
  cmst_in_if.sink    in_bus,
  cmst_out_if.source out_bus
);
  import cmst_pkg::*;

  item_t      item;
  logic       item_valid;
  stage_ctl_t ctl;

  cmst_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .advance    (ctl.advance),
    .item       (item),
    .item_valid (item_valid)
  );

  cmst_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .ctl        (ctl),
    .out_bus    (out_bus)
  );

  // Non-read beats always produce zero read data
  a_idle_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && (item.op != OP_READ)) |=> (out_bus.read_data == '0))
    else $error("read data nonzero on a non-read beat");

  // Interrupt tracks the flags carried on the same beat
  a_irq_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.irq_line == (out_bus.match_flags != '0)))
    else $error("irq line disagrees with match flags");

  // A pending result blocks the core from moving another beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |-> !ctl.advance)
    else $error("result overwritten while stalled");

  // The core only moves a beat that the input stage holds
  a_advance_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance |-> ctl.valid)
    else $error("core advanced with no beat held");

endmodule

### tb/sv/tb_compare_match_system_timer.sv
module tb_compare_match_system_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import cmst_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_BEATS = 1400;
  localparam int DRAIN_CYCLES = 8;

  // One expected result beat
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [FLAG_W-1:0] match_flags;
    logic              irq_line;
  } timer_result_t;

  // Timer predictor plus the queue of results it owes
  class timer_scoreboard;
    bit [CNT_W-1:0]  count;
    bit [DATA_W-1:0] cmp_word [4];
    bit [FLAG_W-1:0] flags;
    timer_result_t   expected_q [$];
    int              errors;

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
    endtask

    // Apply one accepted input beat and queue the result it produces
    function void note_input(op_t op, sel_t sel, logic [DATA_W-1:0] data);
      bit [DATA_W-1:0] rd;
      bit [FLAG_W-1:0] chan_mask;
      timer_result_t   res;
      int              ch;
      chan_mask = FLAG_W'((1 << NUM_CHANNELS) - 1);
      rd = '0;
      case (op)
        OP_TICK: begin
          count = count + 1'b1;
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (cmp_word[i] == count[DATA_W-1:0]) flags[i] = 1'b1;
          end
        end
        OP_READ: begin
          case (sel)
            SEL_STATUS: rd = DATA_W'(flags & chan_mask);
            SEL_CNT_LO: rd = count[DATA_W-1:0];
            SEL_CNT_HI: rd = count[CNT_W-1:DATA_W];
            SEL_CMP0, SEL_CMP1, SEL_CMP2, SEL_CMP3: begin
              ch = int'(sel) - int'(SEL_CMP0);
              if (ch < NUM_CHANNELS) rd = cmp_word[ch];
            end
            default: ;
          endcase
        end
        OP_WRITE: begin
          case (sel)
            // write-one-to-clear, upper data bits ignored
            SEL_STATUS: flags = flags & ~data[FLAG_W-1:0];
            SEL_CMP0, SEL_CMP1, SEL_CMP2, SEL_CMP3: begin
              ch = int'(sel) - int'(SEL_CMP0);
              if (ch < NUM_CHANNELS) cmp_word[ch] = data;
            end
            default: ;  // counter halves and unused select drop writes
          endcase
        end
        default: ;
      endcase
      flags = flags & chan_mask;
      res.read_data   = rd;
      res.match_flags = flags;
      res.irq_line    = |flags;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result beat with the oldest expectation
    task check_result(logic [DATA_W-1:0] rd, logic [FLAG_W-1:0] fl, logic irq);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", rd, '0);
        return;
      end
      want = expected_q.pop_front();
      if (rd !== want.read_data) report_mismatch("read_data", rd, want.read_data);
      if (fl !== want.match_flags)
        report_mismatch("match_flags", DATA_W'(fl), DATA_W'(want.match_flags));
      if (irq !== want.irq_line)
        report_mismatch("irq_line", DATA_W'(irq), DATA_W'(want.irq_line));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   sink_stall_pct;
  int   cycle_count;
  bit [DATA_W-1:0] ticks_sent;
  timer_scoreboard sb;

  cmst_in_if  in_bus ();
  cmst_out_if out_bus ();

  compare_match_system_timer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitor both channels and drive the result-side ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_result(out_bus.read_data, out_bus.match_flags, out_bus.irq_line);
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        sb.note_input(op_t'(in_bus.op), sel_t'(in_bus.reg_select), in_bus.write_data);
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  // Send one beat, with an optional random gap ahead of it
  task send_beat(op_t op, sel_t sel, bit [DATA_W-1:0] data);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.reg_select <= sel;
    in_bus.write_data <= data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (op == OP_TICK) ticks_sent++;
  endtask

  // Hold off the sender until every owed result is back; the extra edge lets
  // the monitor log the last accepted beat first
  task drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random access, biased so compare words land just ahead of the counter
  task send_random_access();
    int              r;
    sel_t            sel;
    bit [DATA_W-1:0] data;
    r = $urandom_range(99);
    if (r < 45) begin
      send_beat(OP_TICK, sel_t'($urandom_range(7)), $urandom());
    end else if (r < 72) begin
      send_beat(OP_READ, sel_t'($urandom_range(7)), $urandom());
    end else if (r < 95) begin
      r = $urandom_range(99);
      if (r < 55) begin
        sel = sel_t'(int'(SEL_CMP0) + $urandom_range(3));
        r = $urandom_range(99);
        if (r < 65)      data = ticks_sent + DATA_W'($urandom_range(12, 1));
        else if (r < 80) data = ticks_sent;
        else             data = $urandom();
      end else if (r < 85) begin
        sel  = SEL_STATUS;
        data = $urandom_range(1) ? DATA_W'(1) << $urandom_range(FLAG_W - 1) : $urandom();
      end else begin
        r = $urandom_range(2);
        sel  = (r == 0) ? SEL_CNT_LO : (r == 1) ? SEL_CNT_HI : SEL_NONE;
        data = $urandom();
      end
      send_beat(OP_WRITE, sel, data);
    end else begin
      send_beat(OP_NOP, sel_t'($urandom_range(7)), $urandom());
    end
  endtask

  // Stimulus
  initial begin
    sb = new();
    rst_n             = 1'b0;
    sender_idle_pct   = 0;
    sink_stall_pct    = 0;
    cycle_count       = 0;
    ticks_sent        = '0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_TICK;
    in_bus.reg_select = SEL_STATUS;
    in_bus.write_data = '0;
    out_bus.ready     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, matches, clears, dropped writes, unused codes.
    // Counter wrap needs 2^64 ticks and is out of reach.
    send_beat(OP_READ, SEL_STATUS, '0);
    send_beat(OP_READ, SEL_CNT_LO, '0);
    send_beat(OP_READ, SEL_CNT_HI, '0);
    send_beat(OP_READ, SEL_CMP0, '0);
    send_beat(OP_READ, SEL_NONE, '0);
    send_beat(OP_WRITE, SEL_CMP0, 32'd1);
    send_beat(OP_WRITE, SEL_CMP1, 32'd2);
    send_beat(OP_WRITE, SEL_CMP2, 32'd3);
    send_beat(OP_WRITE, SEL_CMP3, 32'hFFFF_FFFF);
    send_beat(OP_TICK, SEL_STATUS, '0);
    send_beat(OP_TICK, SEL_STATUS, '0);
    send_beat(OP_TICK, SEL_NONE, 32'hFFFF_FFFF);
    send_beat(OP_READ, SEL_STATUS, '0);
    send_beat(OP_WRITE, SEL_CNT_LO, 32'hFFFF_FFFF);
    send_beat(OP_WRITE, SEL_CNT_HI, 32'hFFFF_FFFF);
    send_beat(OP_READ, SEL_CNT_LO, '0);
    send_beat(OP_WRITE, SEL_STATUS, 32'hFFFF_FFF2);
    send_beat(OP_READ, SEL_STATUS, '0);
    send_beat(OP_WRITE, SEL_STATUS, 32'hFFFF_FFFF);
    send_beat(OP_WRITE, SEL_NONE, 32'hFFFF_FFFF);
    send_beat(OP_READ, SEL_NONE, '0);
    send_beat(OP_NOP, SEL_CMP3, 32'hFFFF_FFFF);
    send_beat(OP_READ, SEL_CMP3, '0);
    drain_results();

    // Random, four idle profiles, draining between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin sender_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      for (int n = 0; n < RANDOM_BEATS / 4; n++) send_random_access();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/cmst_pkg.sv
design/cmst_if.sv
design/cmst_in_stage.sv
design/cmst_core.sv
design/compare_match_system_timer.sv
tb/sv/tb_compare_match_system_timer.sv
